// ===== rtl/u2c_pkg.sv =====
// ----------------------------------------------------------------------------
// u2c_pkg: shared types and constants for the UTF-8 to CP1251 converter
// Result word layout, status codes, queue sizing and the reverse code table.
// ----------------------------------------------------------------------------
package u2c_pkg;

  localparam logic [1:0] STATUS_CHAR = 2'd0;
  localparam logic [1:0] STATUS_END  = 2'd1;
  localparam logic [1:0] STATUS_FAIL = 2'd2;

  localparam int Q_DEPTH   = 4;
  localparam int TABLE_LEN = 61;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } result_t;

  // Up to two result words per input word; valid1 implies valid0.
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t r0;
    result_t r1;
  } push_t;

  localparam logic [7:0] MAP_BYTE [TABLE_LEN] = '{
    8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C,
    8'h8D, 8'h8E, 8'h8F, 8'h90, 8'h91, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97,
    8'h99, 8'h9A, 8'h9B, 8'h9C, 8'h9D, 8'h9E, 8'h9F, 8'hA0, 8'hA1, 8'hA2, 8'hA3,
    8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA, 8'hAB, 8'hAC, 8'hAD, 8'hAE,
    8'hAF, 8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9,
    8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF
  };

  localparam logic [15:0] MAP_CODE [TABLE_LEN] = '{
    16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021, 16'h20AC,
    16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
    16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013,
    16'h2014, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B,
    16'h045F, 16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490,
    16'h00A6, 16'h00A7, 16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC,
    16'h00AD, 16'h00AE, 16'h0407, 16'h00B0, 16'h00B1, 16'h0406, 16'h0456,
    16'h0491, 16'h00B5, 16'h00B6, 16'h00B7, 16'h0451, 16'h2116, 16'h0454,
    16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457
  };

endpackage

// ===== rtl/u2c_if.sv =====
// ----------------------------------------------------------------------------
// u2c channel interfaces
// Valid/ready channels for input bytes and converted result words.
// ----------------------------------------------------------------------------
interface u2c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u2c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== rtl/u2c_mapper.sv =====
// ----------------------------------------------------------------------------
// u2c_mapper: 11-bit code point to CP1251 byte
// Range rules first, then a parallel match against the reverse table.
// ----------------------------------------------------------------------------
module u2c_mapper (
  input  logic [10:0] code_point,
  output logic        hit,
  output logic [7:0]  res_byte
);

  logic [10:0] cyr_diff;
  logic [10:0] dje_diff;
  logic        tbl_hit;
  logic [7:0]  tbl_byte;

  assign cyr_diff = code_point - 11'h350;
  assign dje_diff = code_point - 11'h382;

  // Table codes are unique, so an OR of the matching entries is the lookup.
  always_comb begin
    tbl_hit  = 1'b0;
    tbl_byte = 8'h00;
    for (int k = 0; k < u2c_pkg::TABLE_LEN; k++) begin
      if ({5'b0, code_point} == u2c_pkg::MAP_CODE[k]) begin
        tbl_hit  = 1'b1;
        tbl_byte = tbl_byte | u2c_pkg::MAP_BYTE[k];
      end
    end
  end

  always_comb begin
    hit      = 1'b1;
    res_byte = 8'h00;
    if (code_point >= 11'h410 && code_point <= 11'h44F) begin
      res_byte = cyr_diff[7:0];
    end else if (code_point >= 11'h080 && code_point <= 11'h0FF) begin
      res_byte = code_point[7:0];
    end else if (code_point >= 11'h402 && code_point <= 11'h403) begin
      res_byte = dje_diff[7:0];
    end else begin
      hit      = tbl_hit;
      res_byte = tbl_byte;
    end
  end

endmodule

// ===== rtl/u2c_core.sv =====
// ----------------------------------------------------------------------------
// u2c_core: input register, decode state and per-byte decode
// Holds one input word, decodes it against the lead/discard state and
// pushes up to two result words when the queue has room.
// ----------------------------------------------------------------------------
module u2c_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte,
  input  logic             end_of_string,
  input  logic             can_push,
  output u2c_pkg::push_t   push
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_end;
  logic       s1_move;

  logic       lead_pending, lead_pending_next;
  logic [4:0] lead_bits, lead_bits_next;
  logic       discarding, discarding_next;

  logic       map_hit;
  logic [7:0] map_byte;
  logic       stop;

  u2c_pkg::push_t dec;

  localparam u2c_pkg::result_t RES_END  = '{out_byte: 8'h00, status: u2c_pkg::STATUS_END,
                                            last: 1'b1};
  localparam u2c_pkg::result_t RES_FAIL = '{out_byte: 8'h00, status: u2c_pkg::STATUS_FAIL,
                                            last: 1'b1};

  assign s1_move  = s1_valid && can_push;
  assign in_ready = !s1_valid || can_push;
  assign stop     = (s1_byte == 8'h00) || s1_end;

  u2c_mapper u_mapper (
    .code_point ({lead_bits, s1_byte[5:0]}),
    .hit        (map_hit),
    .res_byte   (map_byte)
  );

  always_comb begin
    lead_pending_next = lead_pending;
    lead_bits_next    = lead_bits;
    discarding_next   = discarding;
    dec               = '0;
    if (discarding) begin
      if (stop) begin
        discarding_next = 1'b0;
      end
    end else if (lead_pending) begin
      lead_pending_next = 1'b0;
      lead_bits_next    = 5'd0;
      dec.valid0        = 1'b1;
      if (!map_hit) begin
        dec.r0          = RES_FAIL;
        discarding_next = !stop;
      end else begin
        dec.r0 = '{out_byte: map_byte, status: u2c_pkg::STATUS_CHAR, last: 1'b0};
        if (s1_end) begin
          dec.valid1 = 1'b1;
          dec.r1     = RES_END;
        end
      end
    end else if (s1_byte == 8'h00) begin
      dec.valid0 = 1'b1;
      dec.r0     = RES_END;
    end else if (!s1_byte[7]) begin
      dec.valid0 = 1'b1;
      dec.r0     = '{out_byte: s1_byte, status: u2c_pkg::STATUS_CHAR, last: 1'b0};
      if (s1_end) begin
        dec.valid1 = 1'b1;
        dec.r1     = RES_END;
      end
    end else if (s1_byte[5]) begin
      dec.valid0      = 1'b1;
      dec.r0          = RES_FAIL;
      discarding_next = !stop;
    end else if (s1_end) begin
      // lead byte with no room left for its continuation
      dec.valid0 = 1'b1;
      dec.r0     = RES_FAIL;
    end else begin
      lead_pending_next = 1'b1;
      lead_bits_next    = s1_byte[4:0];
    end
  end

  always_comb begin
    push        = dec;
    push.valid0 = dec.valid0 && s1_move;
    push.valid1 = dec.valid1 && s1_move;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      lead_pending <= 1'b0;
      lead_bits    <= 5'd0;
      discarding   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_move) begin
        lead_pending <= lead_pending_next;
        lead_bits    <= lead_bits_next;
        discarding   <= discarding_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
      s1_end  <= end_of_string;
    end
  end

endmodule

// ===== rtl/u2c_queue.sv =====
// ----------------------------------------------------------------------------
// u2c_queue: result word queue
// Takes up to two words per cycle, hands out one per cycle to a ready sink.
// ----------------------------------------------------------------------------
module u2c_queue (
  input  logic              clk,
  input  logic              rst,
  input  u2c_pkg::push_t    push,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output u2c_pkg::result_t  out_word
);

  localparam int PW = $clog2(u2c_pkg::Q_DEPTH);
  localparam int CW = $clog2(u2c_pkg::Q_DEPTH + 1);

  u2c_pkg::result_t mem [u2c_pkg::Q_DEPTH];

  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] push_n;
  logic [CW-1:0] pop_n;
  logic          pop;

  assign pop       = out_valid && out_ready;
  assign push_n    = {{(CW-1){1'b0}}, push.valid0} + {{(CW-1){1'b0}}, push.valid1};
  assign pop_n     = {{(CW-1){1'b0}}, pop};
  // keep room for a two-word push
  assign can_push  = count <= CW'(u2c_pkg::Q_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_n[PW-1:0];
      rd_ptr <= rd_ptr + {{(PW-1){1'b0}}, pop};
      count  <= count + push_n - pop_n;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.valid1) begin
      mem[wr_ptr + 1'b1] <= push.r1;
    end
  end

endmodule

// ===== rtl/utf8_to_cp1251_stream.sv =====
// An input word is registered, decoded into the queue when it has room; its
// first result is offered once queued. Throughput: one input word per cycle
// while the queue has room for two words; the output port moves one word per
// cycle, so a byte with two results (character plus end) leaves as two words.
// Reset (rst, synchronous, active high) clears the decode state and empties
// the queue; no clearing pass, the block accepts words right after reset.
// ----------------------------------------------------------------------------
// utf8_to_cp1251_stream: UTF-8 to Windows-1251 byte stream converter
// ASCII passes through, two-byte sequences are mapped to CP1251, and each
// string closes with an end or failure word.
// ----------------------------------------------------------------------------
module utf8_to_cp1251_stream (
  input  logic       clk,
  input  logic       rst,
  u2c_in_if.sink     in_ch,
  u2c_out_if.source  out_ch
);

  // push bundle from the decoder into the queue
  u2c_pkg::push_t   push;
  u2c_pkg::result_t out_word;
  logic             can_push;

  // Input register plus decode: hold one word, advance when the queue has
  // space for both possible results, drop bytes while skipping a failed string.
  u2c_core u_core (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_byte       (in_ch.in_byte),
    .end_of_string (in_ch.end_of_string),
    .can_push      (can_push),
    .push          (push)
  );

  // Result queue: parts the input side from the output so a stalled sink
  // does not stop intake until the queue has no room for two words.
  u2c_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .can_push  (can_push),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign out_ch.out_byte = out_word.out_byte;
  assign out_ch.status   = out_word.status;
  assign out_ch.last     = out_word.last;

endmodule
